FILE: rtl/rtcpp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RTCP compound packet parser package
// Shared constants and the result word type.
// ----------------------------------------------------------------------------
package rtcpp_pkg;

    localparam int unsigned MAX_PACKETS_DEF = 16;
    localparam int unsigned OFFSET_W        = 18;

    localparam logic [7:0] TYPE_SR   = 8'd200;
    localparam logic [7:0] TYPE_SDES = 8'd202;

    typedef struct packed {
        logic [1:0]  version;
        logic        padding;
        logic [4:0]  report_count;
        logic [7:0]  packet_type;
        logic [15:0] length_words;
        logic [31:0] source_id;
        logic [63:0] ntp_time;
        logic [31:0] media_timestamp;
        logic [31:0] sent_packets;
        logic [31:0] sent_octets;
        logic [7:0]  item_type;
        logic [3:0]  packet_number;
    } result_t;

endpackage
`default_nettype wire

FILE: rtl/rtcpp_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RTCP parser channel interfaces
// Byte input channel and per-packet result channel, valid/ready.
// ----------------------------------------------------------------------------
interface rtcpp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface rtcpp_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  version;
    logic        padding;
    logic [4:0]  report_count;
    logic [7:0]  packet_type;
    logic [15:0] length_words;
    logic [31:0] source_id;
    logic [63:0] ntp_time;
    logic [31:0] media_timestamp;
    logic [31:0] sent_packets;
    logic [31:0] sent_octets;
    logic [7:0]  item_type;
    logic [3:0]  packet_number;

    modport source (
        output valid, output version, output padding, output report_count,
        output packet_type, output length_words, output source_id, output ntp_time,
        output media_timestamp, output sent_packets, output sent_octets,
        output item_type, output packet_number, input ready
    );
    modport sink (
        input valid, input version, input padding, input report_count,
        input packet_type, input length_words, input source_id, input ntp_time,
        input media_timestamp, input sent_packets, input sent_octets,
        input item_type, input packet_number, output ready
    );
endinterface
`default_nettype wire

FILE: rtl/rtcpp_skid.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RTCP parser result stage
// Output register plus one skid entry; full only when both are occupied.
// ----------------------------------------------------------------------------
module rtcpp_skid (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire rtcpp_pkg::result_t word,
    output logic                    full,
    rtcpp_result_if.source          result
);

    rtcpp_pkg::result_t out_reg;
    rtcpp_pkg::result_t skid_reg;
    logic               out_valid_reg;
    logic               skid_valid_reg;
    logic               pop;

    assign pop  = out_valid_reg && result.ready;
    assign full = skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_reg <= word;
            end
            else
            begin
                skid_reg <= word;
            end
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.version         = out_reg.version;
    assign result.padding         = out_reg.padding;
    assign result.report_count    = out_reg.report_count;
    assign result.packet_type     = out_reg.packet_type;
    assign result.length_words    = out_reg.length_words;
    assign result.source_id       = out_reg.source_id;
    assign result.ntp_time        = out_reg.ntp_time;
    assign result.media_timestamp = out_reg.media_timestamp;
    assign result.sent_packets    = out_reg.sent_packets;
    assign result.sent_octets     = out_reg.sent_octets;
    assign result.item_type       = out_reg.item_type;
    assign result.packet_number   = out_reg.packet_number;

endmodule
`default_nettype wire

FILE: rtl/rtcp_compound_packet_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RTCP compound packet parser
// Byte-serial decode of compound RTCP: header, sender report and SDES fields,
// one result word per packet.
//
//   channel   dir   word contents
//   payload   in    data_byte, last_byte
//   result    out   header fields, SR fields, SDES item type, packet number
//
// One byte accepted per cycle while payload.ready is high; a byte's fields
// land in the state registers at the same edge. A packet's result word is
// loaded then too, into the output register (offered from the next cycle) or,
// if that still holds a word, into the skid entry. payload.ready drops only
// when both are full, after the result side stalls with two packets pending.
// Reset (rst_n, async, active low) clears offset, packet count and all state.
// ----------------------------------------------------------------------------
module rtcp_compound_packet_parser #(
    parameter int unsigned MAX_PACKETS = rtcpp_pkg::MAX_PACKETS_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    rtcpp_byte_if.sink      payload,
    rtcpp_result_if.source  result
);

    localparam int unsigned CNT_W = (MAX_PACKETS > 1) ? $clog2(MAX_PACKETS) : 1;
    localparam int unsigned OFF_W = rtcpp_pkg::OFFSET_W;

    logic [OFF_W-1:0] offset_reg,    offset_next;
    logic [31:0]      header_reg,    header_next;
    logic [31:0]      ssrc_reg,      ssrc_next;
    logic [63:0]      ntp_reg,       ntp_next;
    logic [31:0]      rpt_reg [3],   rpt_next [3];
    logic [7:0]       item_reg,      item_next;
    logic [CNT_W-1:0] cnt_reg,       cnt_next;
    logic [31:0]      last_sr_reg,   last_sr_next;
    logic [31:0]      peer_reg,      peer_next;

    logic             accept;
    logic             emit;
    logic             skid_full;
    logic [7:0]       ptype;
    logic             is_sr;
    logic             is_sdes;
    logic [OFF_W:0]   off_inc;
    logic [OFF_W:0]   end_off;
    logic [1:0]       rpt_idx;
    rtcpp_pkg::result_t word;

    function automatic logic [7:0] rpt_sdes_sr(input logic sr);
        rpt_sdes_sr = sr ? rtcpp_pkg::TYPE_SR : rtcpp_pkg::TYPE_SDES;
    endfunction

    assign accept        = payload.valid && payload.ready;
    assign payload.ready = !skid_full;

    always_comb
    begin
        header_next  = (offset_reg == '0) ? '0 : header_reg;
        ssrc_next    = (offset_reg == '0) ? '0 : ssrc_reg;
        ntp_next     = (offset_reg == '0) ? '0 : ntp_reg;
        item_next    = (offset_reg == '0) ? '0 : item_reg;
        for (int i = 0; i < 3; i++)
        begin
            rpt_next[i] = (offset_reg == '0) ? '0 : rpt_reg[i];
        end
        last_sr_next = last_sr_reg;
        peer_next    = peer_reg;
        ptype        = header_reg[23:16];
        is_sr        = (ptype == rpt_sdes_sr(1'b1));
        is_sdes      = (ptype == rpt_sdes_sr(1'b0));
        rpt_idx      = 2'(offset_reg[4:2] - 3'd4);

        if (offset_reg < OFF_W'(4))
        begin
            header_next[8*(2'd3 - offset_reg[1:0]) +: 8] = payload.data_byte;
        end
        else if (offset_reg < OFF_W'(8) && (is_sr || is_sdes))
        begin
            ssrc_next[8*(2'd3 - offset_reg[1:0]) +: 8] = payload.data_byte;
            if (offset_reg == OFF_W'(7) && is_sr)
            begin
                peer_next = ssrc_next;
            end
        end
        else if (is_sr && offset_reg < OFF_W'(16))
        begin
            ntp_next[8*(3'd7 - offset_reg[2:0]) +: 8] = payload.data_byte;
            if (offset_reg == OFF_W'(15))
            begin
                last_sr_next = ntp_next[47:16];
            end
        end
        else if (is_sr && offset_reg < OFF_W'(28))
        begin
            rpt_next[rpt_idx][8*(2'd3 - offset_reg[1:0]) +: 8] = payload.data_byte;
        end
        else if (is_sdes && offset_reg == OFF_W'(8))
        begin
            item_next = payload.data_byte;
        end

        off_inc = {1'b0, offset_reg} + (OFF_W+1)'(1);
        end_off = (OFF_W+1)'({header_next[15:0], 2'b00}) + (OFF_W+1)'(4);
        emit    = payload.last_byte
               || ((offset_reg >= OFF_W'(3)) && (off_inc == end_off));

        offset_next = emit ? '0 : off_inc[OFF_W-1:0];

        cnt_next = cnt_reg;
        if (emit)
        begin
            if (payload.last_byte)
            begin
                cnt_next = '0;
            end
            else if (cnt_reg < CNT_W'(MAX_PACKETS - 1))
            begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end
    end

    always_comb
    begin
        word.version         = header_next[31:30];
        word.padding         = header_next[29];
        word.report_count    = header_next[28:24];
        word.packet_type     = header_next[23:16];
        word.length_words    = header_next[15:0];
        word.source_id       = (header_next[23:16] == rtcpp_pkg::TYPE_SR
                             || header_next[23:16] == rtcpp_pkg::TYPE_SDES)
                             ? ssrc_next : '0;
        word.ntp_time        = ntp_next;
        word.media_timestamp = rpt_next[0];
        word.sent_packets    = rpt_next[1];
        word.sent_octets     = rpt_next[2];
        word.item_type       = (header_next[23:16] == rtcpp_pkg::TYPE_SDES)
                             ? item_next : '0;
        word.packet_number   = 4'(cnt_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg  <= '0;
            header_reg  <= '0;
            ssrc_reg    <= '0;
            ntp_reg     <= '0;
            rpt_reg[0]  <= '0;
            rpt_reg[1]  <= '0;
            rpt_reg[2]  <= '0;
            item_reg    <= '0;
            cnt_reg     <= '0;
            last_sr_reg <= '0;
            peer_reg    <= '0;
        end
        else if (accept)
        begin
            offset_reg  <= offset_next;
            header_reg  <= header_next;
            ssrc_reg    <= ssrc_next;
            ntp_reg     <= ntp_next;
            rpt_reg[0]  <= rpt_next[0];
            rpt_reg[1]  <= rpt_next[1];
            rpt_reg[2]  <= rpt_next[2];
            item_reg    <= item_next;
            cnt_reg     <= cnt_next;
            last_sr_reg <= last_sr_next;
            peer_reg    <= peer_next;
        end
    end

    rtcpp_skid u_skid (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (accept && emit),
        .word   (word),
        .full   (skid_full),
        .result (result)
    );

`ifndef SYNTHESIS
    a_stall_needs_output: assert property (@(posedge clk) disable iff (!rst_n)
        !payload.ready |-> result.valid)
        else $error("input stalled with no result word pending");

    a_end_of_payload: assert property (@(posedge clk) disable iff (!rst_n)
        accept && payload.last_byte |=> (offset_reg == '0) && (cnt_reg == '0))
        else $error("offset or packet count not cleared after last byte");

    a_last_sr: assert property (@(posedge clk) disable iff (!rst_n)
        accept && is_sr && (offset_reg == OFF_W'(15))
        |=> last_sr_reg == ntp_reg[47:16])
        else $error("last-SR value does not match NTP middle bits");

    a_peer_ssrc: assert property (@(posedge clk) disable iff (!rst_n)
        accept && is_sr && (offset_reg == OFF_W'(7)) |=> peer_reg == ssrc_reg)
        else $error("peer SSRC not captured from sender report");
`endif

endmodule
`default_nettype wire

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTCP compound packet parser testbench
// Streams compound payloads (sender reports, SDES, other types, truncated
// and oversize packets) into the parser and predicts every result word from
// a byte-level decoder of its own. Both channels idle at random, and the
// result side holds off for long stretches so that the input back-pressures.
// ----------------------------------------------------------------------------
module tb_top;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } pay_word_t;

    localparam int unsigned PKT_SAT = rtcpp_pkg::MAX_PACKETS_DEF - 1;

    logic clk;
    logic rst_n = 1'b0;

    rtcpp_byte_if   byte_ch ();
    rtcpp_result_if result_ch ();

    rtcp_compound_packet_parser u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .payload (byte_ch.sink),
        .result  (result_ch.source)
    );

    pay_word_t           byte_q[$];
    rtcpp_pkg::result_t  expected_results[$];
    pay_word_t           tx_word;
    int unsigned tx_gap;
    int unsigned rx_gap;
    int unsigned hold_left;
    int unsigned holds_done;
    int unsigned bytes_taken;
    int unsigned calm_left;
    bit          calm;
    int unsigned err_count;

    // decoder state
    logic [17:0] byte_off;
    logic [31:0] hdr_word;
    logic [31:0] src_word;
    logic [63:0] sr_fields[4];
    logic [7:0]  sdes_item;
    int unsigned pkt_index;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_error(input string msg);
        err_count++;
        $display("ERROR at %0t: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] exp);
        if (got !== exp)
            report_error($sformatf("%s got %0h exp %0h", name, got, exp));
    endtask

    // One payload byte through the decoder; pushes a result when a packet closes.
    task automatic parse_byte(input logic [7:0] b, input logic lst);
        int unsigned        off;
        int unsigned        k;
        int unsigned        len;
        logic [7:0]         pt;
        bit                 done;
        rtcpp_pkg::result_t r;
        off = byte_off;
        if (off == 0)
        begin
            hdr_word  = '0;
            src_word  = '0;
            sr_fields = '{default: '0};
            sdes_item = '0;
        end
        if (off < 4)
            hdr_word |= 32'(b) << (8 * (3 - off));
        else
        begin
            pt = hdr_word[23:16];
            if (off < 8 && (pt == rtcpp_pkg::TYPE_SR || pt == rtcpp_pkg::TYPE_SDES))
                src_word |= 32'(b) << (8 * (7 - off));
            else if (pt == rtcpp_pkg::TYPE_SR && off < 16)
                sr_fields[0] |= 64'(b) << (8 * (15 - off));
            else if (pt == rtcpp_pkg::TYPE_SR && off < 28)
            begin
                k = (off - 16) >> 2;
                sr_fields[1 + k] |= 64'(b) << (8 * (3 - ((off - 16) & 3)));
            end
            else if (pt == rtcpp_pkg::TYPE_SDES && off == 8)
                sdes_item = b;
        end
        len  = hdr_word[15:0];
        done = (off >= 3) && (off + 1 == (len + 1) * 4);
        if (!done && !lst)
        begin
            byte_off = 18'(off + 1);
            return;
        end
        pt                = hdr_word[23:16];
        r.version         = hdr_word[31:30];
        r.padding         = hdr_word[29];
        r.report_count    = hdr_word[28:24];
        r.packet_type     = pt;
        r.length_words    = hdr_word[15:0];
        r.source_id       = (pt == rtcpp_pkg::TYPE_SR || pt == rtcpp_pkg::TYPE_SDES)
                          ? src_word : '0;
        r.ntp_time        = sr_fields[0];
        r.media_timestamp = sr_fields[1][31:0];
        r.sent_packets    = sr_fields[2][31:0];
        r.sent_octets     = sr_fields[3][31:0];
        r.item_type       = (pt == rtcpp_pkg::TYPE_SDES) ? sdes_item : '0;
        r.packet_number   = 4'(pkt_index);
        expected_results.push_back(r);
        byte_off = '0;
        if (lst)
            pkt_index = 0;
        else if (pkt_index < PKT_SAT)
            pkt_index++;
    endtask

    // hb < 0 picks a random first header byte; cut truncates the packet and ends the payload.
    task automatic send_packet(input logic [7:0] ptype, input logic [15:0] len,
                               input int cut, input bit end_pay, input int hb);
        int        full;
        int        n;
        pay_word_t w;
        full = (int'(len) + 1) * 4;
        n    = (cut > 0 && cut < full) ? cut : full;
        for (int i = 0; i < n; i++)
        begin
            case (i)
                0:       w.data = (hb >= 0) ? 8'(hb) :
                                  {(($urandom_range(0, 9) == 0) ? 2'($urandom) : 2'd2),
                                   6'($urandom)};
                1:       w.data = ptype;
                2:       w.data = len[15:8];
                3:       w.data = len[7:0];
                default: w.data = 8'($urandom);
            endcase
            w.last = (i == n - 1) && (n < full || end_pay);
            byte_q.push_back(w);
        end
    endtask

    task automatic send_random_payload();
        int unsigned npk;
        int unsigned r;
        bit          big;
        logic [7:0]  pt;
        logic [15:0] len;
        int          cut;
        int          full;
        big = ($urandom_range(0, 7) == 0);
        npk = big ? $urandom_range(16, 20) : $urandom_range(1, 6);
        for (int p = 0; p < npk; p++)
        begin
            r = $urandom_range(0, 99);
            if (r < 40)
            begin
                pt  = rtcpp_pkg::TYPE_SR;
                len = ($urandom_range(0, 9) < 7) ? 16'd6 : 16'($urandom_range(0, 12));
            end
            else if (r < 70)
            begin
                pt  = rtcpp_pkg::TYPE_SDES;
                len = 16'($urandom_range(0, 6));
            end
            else if (r < 80)
            begin
                pt  = 8'($urandom_range(192, 207));
                len = 16'($urandom_range(0, 4));
            end
            else
            begin
                pt  = 8'($urandom);
                len = 16'($urandom_range(0, 4));
            end
            if (big)
                len = 16'($urandom_range(0, 1));
            cut  = 0;
            full = (int'(len) + 1) * 4;
            r    = $urandom_range(0, 99);
            if (r < 5)
            begin
                len = 16'($urandom);
                cut = $urandom_range(1, 40);
            end
            else if (r < 13 && full > 1)
                cut = $urandom_range(1, full - 1);
            send_packet(pt, len, cut, (p == npk - 1), -1);
            if (cut > 0)
                break;
        end
    endtask

    // payload driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_ch.valid     <= 1'b0;
            byte_ch.data_byte <= '0;
            byte_ch.last_byte <= 1'b0;
            tx_gap            <= 0;
        end
        else if (!byte_ch.valid || byte_ch.ready)
        begin
            if (tx_gap > 0)
            begin
                tx_gap        <= tx_gap - 1;
                byte_ch.valid <= 1'b0;
            end
            else if (byte_q.size() > 0)
            begin
                tx_word            = byte_q.pop_front();
                byte_ch.valid     <= 1'b1;
                byte_ch.data_byte <= tx_word.data;
                byte_ch.last_byte <= tx_word.last;
                tx_gap            <= pick_gap();
            end
            else
                byte_ch.valid <= 1'b0;
        end
    end

    // result receiver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            rx_gap          <= 0;
        end
        else if (rx_gap > 0)
        begin
            rx_gap          <= rx_gap - 1;
            result_ch.ready <= 1'b0;
        end
        else
        begin
            result_ch.ready <= (hold_left == 0);
            if ((result_ch.valid && result_ch.ready) || $urandom_range(0, 15) == 0)
                rx_gap <= pick_gap();
        end
    end

    // long result hold-off so the parser fills up and stalls its input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left  <= 0;
            holds_done <= 0;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
        else if (holds_done < 2 && bytes_taken >= 400 + 800 * holds_done)
        begin
            hold_left  <= 300;
            holds_done <= holds_done + 1;
        end
    end

    // stretches with no idling on either side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            calm      <= 1'b0;
            calm_left <= 100;
        end
        else if (calm_left == 0)
        begin
            calm      <= ~calm;
            calm_left <= $urandom_range(50, 400);
        end
        else
            calm_left <= calm_left - 1;
    end

    // monitor: predict on accepted bytes, check accepted result words
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_off    = '0;
            hdr_word    = '0;
            src_word    = '0;
            sr_fields   = '{default: '0};
            sdes_item   = '0;
            pkt_index   = 0;
            bytes_taken <= 0;
        end
        else
        begin
            if (byte_ch.valid && byte_ch.ready)
            begin
                parse_byte(byte_ch.data_byte, byte_ch.last_byte);
                bytes_taken <= bytes_taken + 1;
            end
            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_results.size() == 0)
                    report_error("result word with none expected");
                else
                begin
                    rtcpp_pkg::result_t e;
                    e = expected_results.pop_front();
                    check_field("version", result_ch.version, e.version);
                    check_field("padding", result_ch.padding, e.padding);
                    check_field("report_count", result_ch.report_count, e.report_count);
                    check_field("packet_type", result_ch.packet_type, e.packet_type);
                    check_field("length_words", result_ch.length_words, e.length_words);
                    check_field("source_id", result_ch.source_id, e.source_id);
                    check_field("ntp_time", result_ch.ntp_time, e.ntp_time);
                    check_field("media_timestamp", result_ch.media_timestamp,
                                e.media_timestamp);
                    check_field("sent_packets", result_ch.sent_packets, e.sent_packets);
                    check_field("sent_octets", result_ch.sent_octets, e.sent_octets);
                    check_field("item_type", result_ch.item_type, e.item_type);
                    check_field("packet_number", result_ch.packet_number, e.packet_number);
                end
            end
        end
    end

    initial
    begin
        err_count = 0;

        // directed: compound SR + SDES + other, short SR, truncations, header extremes
        send_packet(rtcpp_pkg::TYPE_SR, 16'd6, 0, 1'b0, 8'h80);
        send_packet(rtcpp_pkg::TYPE_SDES, 16'd2, 0, 1'b0, 8'hFF);
        send_packet(8'd201, 16'd0, 0, 1'b1, 8'h00);
        send_packet(rtcpp_pkg::TYPE_SR, 16'd2, 0, 1'b1, -1);
        send_packet(rtcpp_pkg::TYPE_SR, 16'd7, 0, 1'b1, -1);
        send_packet(rtcpp_pkg::TYPE_SR, 16'hFFFF, 20, 1'b1, -1);
        send_packet(rtcpp_pkg::TYPE_SDES, 16'hFFFF, 9, 1'b1, -1);
        send_packet(8'h00, 16'd0, 1, 1'b1, 8'hC0);
        send_packet(8'hFF, 16'h0100, 3, 1'b1, 8'h3F);
        send_packet(rtcpp_pkg::TYPE_SDES, 16'd1, 0, 1'b0, -1);
        send_packet(8'hFF, 16'd0, 0, 1'b1, -1);
        while (byte_q.size() < 1720)
            send_random_payload();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        do @(negedge clk);
        while (byte_q.size() != 0 || byte_ch.valid);
        do @(negedge clk);
        while (expected_results.size() != 0);
        repeat (20) @(posedge clk);
        @(negedge clk);

        if (err_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #12_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: sim.f
rtl/rtcpp_pkg.sv
rtl/rtcpp_ifs.sv
rtl/rtcpp_skid.sv
rtl/rtcp_compound_packet_parser.sv
test/tb_top.sv
